// ===== src/matrix_multiply_add_core_macros.svh =====
// Assertion macros for the matrix multiply-add core.
// Both expect clk and arst_n in the scope of use.
`ifndef MATRIX_MULTIPLY_ADD_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_ADD_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MMA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define MMA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define MMA_ASSERT(lbl, prop, msg)
`define MMA_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== src/mma_pkg.sv =====
package mma_pkg;

	localparam int MAX_DIM_DEF    = 8;
	localparam int ELEM_WIDTH_DEF = 32;
	localparam int DIM_W          = 4;
	localparam int PORT_W         = 32;
	localparam int CFG_IDX_W      = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_A = 2'd0,
		REG_COLS_A = 2'd1,
		REG_ROWS_B = 2'd2,
		REG_COLS_B = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last_k;
		logic eor;
		logic last;
	} mma_tag_t;

endpackage

// ===== src/mma_ram.sv =====
module mma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/matrix_multiply_add_core.sv =====
// Loading: one element word per cycle while no result word waits at the output.
// Compute: after the last B word, each result takes an init step and then one step
// per column of A on the single multiplier, fed by one read of the A store and one of
// the B store per cycle while the output does not stall; no new element is taken until
// the pipeline has drained. Each step passes the store read and product registers.
// Reset: registers to 1, load counter and phase cleared; stores are not cleared.
`include "matrix_multiply_add_core_macros.svh"

module matrix_multiply_add_core #(
	parameter int MAX_DIM    = mma_pkg::MAX_DIM_DEF,
	parameter int ELEM_WIDTH = mma_pkg::ELEM_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mma_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mma_pkg::DIM_W-1:0]           cfg_data,
	input  logic                                element_valid,
	output logic                                element_stall,
	input  logic signed [mma_pkg::PORT_W-1:0]   element,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [mma_pkg::PORT_W-1:0]   result_value,
	output logic                                end_of_row,
	output logic                                last,
	output logic                                dim_error
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W  = mma_pkg::DIM_W;
	localparam int PROD_W = 2 * DIM_W;

	typedef enum logic [1:0] {ST_LOAD, ST_CALC, ST_DRAIN} state_t;

	state_t state_q;

	logic [DIM_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [CNT_W-1:0] load_cnt_q;
	logic             loading_b_q;

	logic [IDX_W-1:0]  i_q, j_q, k_q;
	logic              init_q;
	logic [ADDR_W-1:0] a_row_q, b_ptr_q;

	mma_pkg::mma_tag_t tag_issue, tag_s1_q, tag_s2_q;

	logic [ELEM_WIDTH-1:0] a_rd, b_rd, prod_s2, acc_q, result_q;
	logic                  result_valid_q, eor_q, last_q, dim_err_q;

	logic              elem_acc, cfg_ok, adv, issue;
	logic              a_done, b_done, k_end, j_end, i_end;
	logic [CNT_W-1:0]  load_nxt;
	logic [ADDR_W-1:0] waddr, a_raddr;
	logic [ELEM_WIDTH-1:0] elem_w;

	function automatic logic dim_ok(input logic [DIM_W-1:0] d);
		return (d != '0) && (d <= DIM_W'(MAX_DIM));
	endfunction

	assign cfg_ok = dim_ok(rows_a_q) && dim_ok(cols_a_q) && dim_ok(rows_b_q)
		&& dim_ok(cols_b_q) && (cols_a_q == rows_b_q) && (cols_b_q == cols_a_q);

	assign adv           = !(result_valid_q && result_stall);
	assign element_stall = (state_q != ST_LOAD) || !adv;
	assign elem_acc      = element_valid && !element_stall;
	assign issue         = (state_q == ST_CALC);

	assign load_nxt = load_cnt_q + CNT_W'(1);
	assign a_done   = PROD_W'(load_nxt) >= PROD_W'(rows_a_q) * PROD_W'(cols_a_q);
	assign b_done   = PROD_W'(load_nxt) >= PROD_W'(rows_b_q) * PROD_W'(cols_b_q);
	assign waddr    = load_cnt_q[ADDR_W-1:0];
	assign elem_w   = element[ELEM_WIDTH-1:0];

	assign k_end = (DIM_W'(k_q) == cols_a_q - DIM_W'(1));
	assign j_end = (DIM_W'(j_q) == cols_b_q - DIM_W'(1));
	assign i_end = (DIM_W'(i_q) == rows_a_q - DIM_W'(1));

	assign a_raddr = a_row_q + ADDR_W'(init_q ? j_q : k_q);

	always_comb begin
		tag_issue        = '0;
		tag_issue.valid  = 1'b1;
		tag_issue.first  = init_q;
		tag_issue.last_k = !init_q && k_end;
		tag_issue.eor    = j_end;
		tag_issue.last   = j_end && i_end;
	end

	mma_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_a_ram (
		.clk   (clk),
		.we    (elem_acc && cfg_ok && !loading_b_q),
		.waddr (waddr),
		.wdata (elem_w),
		.re    (adv),
		.raddr (a_raddr),
		.rdata (a_rd)
	);

	mma_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_b_ram (
		.clk   (clk),
		.we    (elem_acc && cfg_ok && loading_b_q),
		.waddr (waddr),
		.wdata (elem_w),
		.re    (adv),
		.raddr (b_ptr_q),
		.rdata (b_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			rows_a_q       <= DIM_W'(1);
			cols_a_q       <= DIM_W'(1);
			rows_b_q       <= DIM_W'(1);
			cols_b_q       <= DIM_W'(1);
			load_cnt_q     <= '0;
			loading_b_q    <= 1'b0;
			i_q            <= '0;
			j_q            <= '0;
			k_q            <= '0;
			init_q         <= 1'b1;
			a_row_q        <= '0;
			b_ptr_q        <= '0;
			tag_s1_q       <= '0;
			tag_s2_q       <= '0;
			result_valid_q <= 1'b0;
			eor_q          <= 1'b0;
			last_q         <= 1'b0;
			dim_err_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (mma_pkg::cfg_reg_t'(cfg_index))
					mma_pkg::REG_ROWS_A: rows_a_q <= cfg_data;
					mma_pkg::REG_COLS_A: cols_a_q <= cfg_data;
					mma_pkg::REG_ROWS_B: rows_b_q <= cfg_data;
					mma_pkg::REG_COLS_B: cols_b_q <= cfg_data;
					default: ;
				endcase
			end

			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			if (elem_acc) begin
				if (!cfg_ok) begin
					load_cnt_q     <= '0;
					loading_b_q    <= 1'b0;
					result_valid_q <= 1'b1;
					eor_q          <= 1'b0;
					last_q         <= 1'b1;
					dim_err_q      <= 1'b1;
				end else if (!loading_b_q) begin
					if (a_done) begin
						load_cnt_q  <= '0;
						loading_b_q <= 1'b1;
					end else begin
						load_cnt_q <= load_nxt;
					end
				end else if (b_done) begin
					load_cnt_q  <= '0;
					loading_b_q <= 1'b0;
					state_q     <= ST_CALC;
					init_q      <= 1'b1;
					i_q         <= '0;
					j_q         <= '0;
					a_row_q     <= '0;
				end else begin
					load_cnt_q <= load_nxt;
				end
			end

			if (adv) begin
				tag_s1_q <= issue ? tag_issue : '0;
				tag_s2_q <= tag_s1_q;
				if (tag_s2_q.valid && tag_s2_q.last_k) begin
					result_valid_q <= 1'b1;
					eor_q          <= tag_s2_q.eor;
					last_q         <= tag_s2_q.last;
					dim_err_q      <= 1'b0;
				end
				if (issue) begin
					if (init_q) begin
						init_q  <= 1'b0;
						k_q     <= '0;
						b_ptr_q <= ADDR_W'(j_q);
					end else begin
						k_q     <= k_q + IDX_W'(1);
						b_ptr_q <= b_ptr_q + ADDR_W'(cols_b_q);
						if (k_end) begin
							init_q <= 1'b1;
							if (j_end) begin
								j_q     <= '0;
								i_q     <= i_q + IDX_W'(1);
								a_row_q <= a_row_q + ADDR_W'(cols_a_q);
								if (i_end) begin
									state_q <= ST_DRAIN;
								end
							end else begin
								j_q <= j_q + IDX_W'(1);
							end
						end
					end
				end
			end

			if (state_q == ST_DRAIN && !tag_s1_q.valid && !tag_s2_q.valid) begin
				state_q <= ST_LOAD;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= tag_s1_q.first ? a_rd : ELEM_WIDTH'(a_rd * b_rd);
			if (tag_s2_q.valid) begin
				if (tag_s2_q.first) begin
					acc_q <= prod_s2;
				end else begin
					acc_q <= acc_q + prod_s2;
				end
			end
			if (tag_s2_q.valid && tag_s2_q.last_k) begin
				result_q <= acc_q + prod_s2;
			end
		end
		if (elem_acc && !cfg_ok) begin
			result_q <= '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result_value = mma_pkg::PORT_W'(signed'(result_q));
	assign end_of_row   = eor_q;
	assign last         = last_q;
	assign dim_error    = dim_err_q;

	`MMA_ASSERT(a_tag_first_not_last, !(tag_s1_q.valid && tag_s1_q.first && tag_s1_q.last_k), "init step marked as final product")
	`MMA_ASSERT_IMP(a_load_pipe_empty, state_q == ST_LOAD, !tag_s1_q.valid && !tag_s2_q.valid, "pipeline busy while loading")
	`MMA_ASSERT_IMP(a_err_word, result_valid_q && dim_err_q, last_q && !eor_q && result_q == '0, "malformed error word")
	`MMA_ASSERT(a_cnt_range, load_cnt_q < CNT_W'(DEPTH), "load counter beyond store depth")

endmodule
